// ----- rtl/revocation_list_store_top_macros.svh -----
// assertion helpers shared by the revocation list store modules
`ifndef REVOCATION_LIST_STORE_TOP_MACROS_SVH
`define REVOCATION_LIST_STORE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rls_pkg.sv -----
package rls_pkg;

    localparam int ISSUER_SLOTS_DEF       = 8;
    localparam int ENTRIES_PER_ISSUER_DEF = 64;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_STALE      = 3'd1;
    localparam logic [2:0] STS_TABLE_FULL = 3'd2;
    localparam logic [2:0] STS_LIST_FULL  = 3'd3;
    localparam logic [2:0] STS_NO_LOAD    = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [63:0]        issuer_id;
        logic [63:0]        cert_id;
        logic [31:0]        expiry;
        logic signed [63:0] now_time;
    } rls_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       revoked;
    } rls_rsp_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECODE,
        CS_FIND,
        CS_APPLY,
        CS_SETUP,
        CS_SCAN,
        CS_RESP
    } rls_state_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic find_step;
        logic apply;
        logic scan_init;
        logic scan_step;
        logic result_load;
    } rls_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       stale;
        logic       find_last;
        logic       scan_done;
        logic       out_busy;
    } rls_stat_t;

endpackage

// ----- rtl/rls_ctrl.sv -----
module rls_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output rls_pkg::rls_cmd_t  cmd,
    input  rls_pkg::rls_stat_t stat
);
    import rls_pkg::*;

    rls_state_t state_reg;
    rls_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            CS_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = CS_DECODE;
                end
            end
            CS_DECODE:
            begin
                cmd.decode = 1'b1;
                if ((stat.kind == KIND_START && !stat.stale) || stat.kind == KIND_QUERY)
                begin
                    state_next = CS_FIND;
                end
                else
                begin
                    state_next = CS_RESP;
                end
            end
            CS_FIND:
            begin
                cmd.find_step = 1'b1;
                if (stat.find_last)
                begin
                    state_next = (stat.kind == KIND_START) ? CS_APPLY : CS_SETUP;
                end
            end
            CS_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = CS_RESP;
            end
            CS_SETUP:
            begin
                cmd.scan_init = 1'b1;
                state_next    = CS_SCAN;
            end
            CS_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = CS_RESP;
                end
            end
            CS_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

`include "revocation_list_store_top_macros.svh"

    `RLS_ASSERT_NEXT(a_take_decodes, req_valid && !req_stall, state_reg == CS_DECODE, "item taken but no decode")
    `RLS_ASSERT_NOW(a_load_when_free, cmd.result_load, state_reg == CS_RESP && !stat.out_busy, "result loaded over a held one")
    `RLS_ASSERT_NEXT(a_find_full_sweep, state_reg == CS_FIND && !stat.find_last, state_reg == CS_FIND, "slot sweep left early")

endmodule

// ----- rtl/rls_datapath.sv -----
module rls_datapath #(
    parameter int ISSUER_SLOTS       = rls_pkg::ISSUER_SLOTS_DEF,
    parameter int ENTRIES_PER_ISSUER = rls_pkg::ENTRIES_PER_ISSUER_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rls_pkg::rls_req_t   req,
    input  rls_pkg::rls_cmd_t   cmd,
    output rls_pkg::rls_stat_t  stat,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rls_pkg::rls_rsp_t   rsp
);
    import rls_pkg::*;

    localparam int DEPTH  = ISSUER_SLOTS * ENTRIES_PER_ISSUER;
    localparam int SLOT_W = (ISSUER_SLOTS > 1) ? $clog2(ISSUER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(ENTRIES_PER_ISSUER + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W:0]   ENT_MUL  = (ADDR_W + 1)'(ENTRIES_PER_ISSUER);
    localparam logic [CNT_W-1:0]  ENT_MAX  = CNT_W'(ENTRIES_PER_ISSUER);
    localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(ISSUER_SLOTS - 1);

    rls_req_t          item_reg;
    logic [63:0]       key_reg [ISSUER_SLOTS];
    logic              used_reg [ISSUER_SLOTS];
    logic [CNT_W-1:0]  cnt_reg [ISSUER_SLOTS];
    logic              load_active_reg;
    logic [SLOT_W-1:0] load_slot_reg;

    logic [SLOT_W-1:0] fs_reg;
    logic              matched_reg;
    logic [SLOT_W-1:0] match_idx_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_idx_reg;

    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  e_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              pend_reg;
    logic              hit_reg;
    logic [2:0]        res_status_reg;

    rls_rsp_t          rsp_reg;
    logic              rsp_valid_reg;

    logic [63:0]       mem [DEPTH];
    logic [63:0]       rd_data_reg;

    logic              stale;
    logic              start_stale;
    logic [CNT_W-1:0]  cur_cnt;
    logic              ent_full;
    logic              is_entry;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              slot_hit;
    logic              slot_free;
    logic              have_slot;
    logic [SLOT_W-1:0] new_slot;

    function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
        return ADDR_W'(ADDR_W'(slot) * ENT_MUL);
    endfunction

    // signed now later than zero-extended nonzero expiry; negative never later
    assign stale = (item_reg.expiry != 32'd0) && !item_reg.now_time[63]
                   && ($unsigned(item_reg.now_time) > {32'd0, item_reg.expiry});
    assign start_stale = (item_reg.kind == KIND_START) && stale;

    assign cur_cnt  = cnt_reg[load_slot_reg];
    assign ent_full = cur_cnt >= ENT_MAX;
    assign is_entry = cmd.decode && item_reg.kind == KIND_ENTRY;
    assign wr_en    = is_entry && load_active_reg && !ent_full;
    assign wr_addr  = slot_base(load_slot_reg) + ADDR_W'(cur_cnt);

    assign rd_en   = cmd.scan_step && (e_reg < n_reg) && !hit_reg;
    assign rd_addr = base_reg + ADDR_W'(e_reg);

    assign slot_hit  = used_reg[fs_reg] && key_reg[fs_reg] == item_reg.issuer_id;
    assign slot_free = !used_reg[fs_reg];
    assign have_slot = matched_reg || free_found_reg;
    assign new_slot  = matched_reg ? match_idx_reg : free_idx_reg;

    assign stat.kind      = item_reg.kind;
    assign stat.stale     = stale;
    assign stat.find_last = fs_reg == SLOT_END;
    assign stat.scan_done = ((e_reg >= n_reg) || hit_reg) && !pend_reg;
    assign stat.out_busy  = rsp_valid_reg && rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.apply && have_slot)
        begin
            key_reg[new_slot] <= item_reg.issuer_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ISSUER_SLOTS; i++)
            begin
                used_reg[i] <= 1'b0;
                cnt_reg[i]  <= '0;
            end
            load_active_reg <= 1'b0;
            load_slot_reg   <= '0;
            res_status_reg  <= STS_OK;
        end
        else
        begin
            if (cmd.decode)
            begin
                if (start_stale)
                begin
                    res_status_reg  <= STS_STALE;
                    load_active_reg <= 1'b0;
                end
                else if (is_entry)
                begin
                    if (!load_active_reg)
                    begin
                        res_status_reg <= STS_NO_LOAD;
                    end
                    else if (ent_full)
                    begin
                        res_status_reg <= STS_LIST_FULL;
                    end
                    else
                    begin
                        res_status_reg         <= STS_OK;
                        cnt_reg[load_slot_reg] <= cur_cnt + 1'b1;
                    end
                end
                else
                begin
                    res_status_reg <= STS_OK;
                end
            end
            if (cmd.apply)
            begin
                if (have_slot)
                begin
                    used_reg[new_slot] <= 1'b1;
                    cnt_reg[new_slot]  <= '0;
                    load_active_reg    <= 1'b1;
                    load_slot_reg      <= new_slot;
                end
                else
                begin
                    res_status_reg  <= STS_TABLE_FULL;
                    load_active_reg <= 1'b0;
                end
            end
        end
    end

    // slot sweep: first matching key, and first free slot for a claim
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg         <= '0;
            matched_reg    <= 1'b0;
            match_idx_reg  <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else if (cmd.decode)
        begin
            fs_reg         <= '0;
            matched_reg    <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.find_step)
        begin
            fs_reg <= fs_reg + 1'b1;
            if (slot_hit && !matched_reg)
            begin
                matched_reg   <= 1'b1;
                match_idx_reg <= fs_reg;
            end
            if (slot_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= fs_reg;
            end
        end
    end

    // entry scan: one read issued per cycle, compared in the cycle after it is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            e_reg    <= '0;
            base_reg <= '0;
            pend_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else if (cmd.capture)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            n_reg    <= matched_reg ? cnt_reg[match_idx_reg] : '0;
            e_reg    <= '0;
            base_reg <= slot_base(match_idx_reg);
            pend_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            pend_reg <= rd_en;
            if (rd_en)
            begin
                e_reg <= e_reg + 1'b1;
            end
            if (pend_reg && rd_data_reg == item_reg.cert_id)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= item_reg.cert_id;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            rsp_reg.status  <= res_status_reg;
            rsp_reg.revoked <= hit_reg;
        end
    end

`include "revocation_list_store_top_macros.svh"

    `RLS_ASSERT_NOW(a_load_slot_used, load_active_reg, used_reg[load_slot_reg], "active load on a free slot")
    `RLS_ASSERT_NEXT(a_stale_ends_load, cmd.decode && start_stale, !load_active_reg, "stale list left load open")
    `RLS_ASSERT_NOW(a_hit_is_ok, rsp_valid_reg && rsp_reg.revoked, rsp_reg.status == STS_OK, "revoked with error status")

endmodule

// ----- rtl/revocation_list_store_top.sv -----
// channel | direction | handshake           | item
// req     | in        | req_valid/req_stall | rls_req_t: kind, issuer, cert, times
// rsp     | out       | rsp_valid/rsp_stall | rls_rsp_t: status, revoked
//
// one item at a time; an entry item goes from decode straight to the result
// a start that is not stale sweeps the key table one slot per cycle, then claims a slot
// a query does the same sweep, then reads the issuer's stored entries one a cycle;
// no reads with no entries, and a hit ends the scan early
// the result register holds while rsp_stall is high; the next item is taken meanwhile
// rst_n clears slot flags, counts and load state at once; no clearing pass
module revocation_list_store_top #(
    parameter int ISSUER_SLOTS       = rls_pkg::ISSUER_SLOTS_DEF,
    parameter int ENTRIES_PER_ISSUER = rls_pkg::ENTRIES_PER_ISSUER_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  rls_pkg::rls_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rls_pkg::rls_rsp_t rsp
);
    import rls_pkg::*;

    rls_cmd_t  cmd;
    rls_stat_t stat;

    rls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    rls_datapath #(
        .ISSUER_SLOTS       (ISSUER_SLOTS),
        .ENTRIES_PER_ISSUER (ENTRIES_PER_ISSUER)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- sim/tb_revocation_list_store_top.sv -----
module tb_revocation_list_store_top;
    import rls_pkg::*;

    localparam int SLOTS = ISSUER_SLOTS_DEF;
    localparam int DEPTH = ENTRIES_PER_ISSUER_DEF;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_ITEMS = 500;
    localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    rls_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    rls_rsp_t rsp;

    always #5 clk = ~clk;

    revocation_list_store_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // shadow copy of the issuer table and revocation lists
    logic [63:0] shadow_keys [SLOTS];
    logic        shadow_used [SLOTS];
    int          shadow_counts [SLOTS];
    logic [63:0] shadow_certs [SLOTS][DEPTH];
    logic        shadow_loading;
    int          shadow_load_slot;

    rls_rsp_t    pending_outcomes [$];
    logic [63:0] issuer_pool [SLOTS];
    logic [63:0] outsider_issuer;
    logic        hold_request = 1'b0;
    int          burst_left;
    int          error_count;
    int          n_starts, n_entries, n_queries, n_ignored;
    int          n_stale, n_table_full, n_list_full, n_no_load, n_hits;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic rls_req_t make_item(logic [1:0] kind, logic [63:0] issuer,
                                           logic [63:0] cert, logic [31:0] nu,
                                           logic [63:0] now_v);
        rls_req_t item;
        item.kind      = kind;
        item.issuer_id = issuer;
        item.cert_id   = cert;
        item.expiry    = nu;
        item.now_time  = now_v;
        return item;
    endfunction

    function automatic int slot_of(logic [63:0] key);
        for (int s = 0; s < SLOTS; s++)
            if (shadow_used[s] && shadow_keys[s] == key)
                return s;
        return SLOTS;
    endfunction

    // expected status and lookup result, updating the shadow store
    function automatic rls_rsp_t crl_outcome(rls_req_t item);
        rls_rsp_t    res;
        int          s;
        logic [63:0] now_u;
        logic        later;
        res = '0;
        case (item.kind)
            KIND_START:
            begin
                now_u = item.now_time;
                // negative times are never later than the expiry
                later = !now_u[63] && (now_u > {32'd0, item.expiry});
                if (item.expiry != 32'd0 && later)
                begin
                    res.status = STS_STALE;
                    shadow_loading = 1'b0;
                end
                else
                begin
                    s = slot_of(item.issuer_id);
                    if (s == SLOTS)
                    begin
                        s = 0;
                        while (s < SLOTS && shadow_used[s])
                            s++;
                    end
                    if (s == SLOTS)
                    begin
                        res.status = STS_TABLE_FULL;
                        shadow_loading = 1'b0;
                    end
                    else
                    begin
                        shadow_keys[s]   = item.issuer_id;
                        shadow_used[s]   = 1'b1;
                        shadow_counts[s] = 0;
                        shadow_loading   = 1'b1;
                        shadow_load_slot = s;
                    end
                end
            end
            KIND_ENTRY:
            begin
                if (!shadow_loading)
                    res.status = STS_NO_LOAD;
                else if (shadow_counts[shadow_load_slot] >= DEPTH)
                    res.status = STS_LIST_FULL;
                else
                begin
                    shadow_certs[shadow_load_slot][shadow_counts[shadow_load_slot]] = item.cert_id;
                    shadow_counts[shadow_load_slot]++;
                end
            end
            KIND_QUERY:
            begin
                s = slot_of(item.issuer_id);
                if (s < SLOTS)
                    for (int i = 0; i < shadow_counts[s]; i++)
                        if (shadow_certs[s][i] == item.cert_id)
                            res.revoked = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_item(rls_req_t item);
        int       gap;
        rls_rsp_t outcome;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        outcome = crl_outcome(item);
        pending_outcomes.insert(pending_outcomes.size(), outcome);
        case (item.kind)
            KIND_START: n_starts++;
            KIND_ENTRY: n_entries++;
            KIND_QUERY: n_queries++;
            default:    n_ignored++;
        endcase
        case (outcome.status)
            STS_STALE:      n_stale++;
            STS_TABLE_FULL: n_table_full++;
            STS_LIST_FULL:  n_list_full++;
            STS_NO_LOAD:    n_no_load++;
            default: ;
        endcase
        if (outcome.revoked)
            n_hits++;
    endtask

    // query that hits a stored cert about half the time when the issuer has any
    task automatic send_known_query(logic [63:0] issuer);
        int          s;
        logic [63:0] cert;
        s = slot_of(issuer);
        if (s < SLOTS && shadow_counts[s] > 0 && $urandom_range(1) == 1)
            cert = shadow_certs[s][$urandom_range(shadow_counts[s] - 1)];
        else
            cert = rand64();
        send_item(make_item(KIND_QUERY, issuer, cert, $urandom, rand64()));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_no_load_and_unknown_kind();
        send_item(make_item(KIND_ENTRY, '0, '1, '0, '0));
        send_item(make_item(KIND_NONE, '1, '1, '1, '1));
        send_item(make_item(KIND_QUERY, issuer_pool[0], '0, '0, '0));
    endtask

    task automatic test_load_and_query();
        logic [63:0] cert;
        cert = rand64();
        // zero expiry never goes stale, even at the latest time
        send_item(make_item(KIND_START, issuer_pool[0], '0, '0, 64'h7fff_ffff_ffff_ffff));
        send_item(make_item(KIND_ENTRY, '0, '1, '0, '0));
        send_item(make_item(KIND_ENTRY, '1, '0, '1, '1));
        send_item(make_item(KIND_QUERY, issuer_pool[0], '1, '0, '0));
        send_item(make_item(KIND_QUERY, issuer_pool[0], 64'd5, '0, '0));
        send_item(make_item(KIND_START, issuer_pool[1], '0, '1, MOST_NEGATIVE));
        send_item(make_item(KIND_ENTRY, '0, cert, '0, '0));
        // lookup in the middle of a load sees what is loaded so far
        send_item(make_item(KIND_QUERY, issuer_pool[1], cert, '0, '0));
        send_item(make_item(KIND_ENTRY, '0, rand64(), '0, '0));
        // a reload of the same issuer empties its list
        send_item(make_item(KIND_START, issuer_pool[0], '0, '0, '0));
        send_item(make_item(KIND_QUERY, issuer_pool[0], '1, '0, '0));
    endtask

    task automatic test_stale_and_time_compare();
        logic [63:0] cert;
        cert = rand64();
        send_item(make_item(KIND_START, issuer_pool[1], '0, 32'd100, 64'd100));
        send_item(make_item(KIND_ENTRY, '0, cert, '0, '0));
        send_item(make_item(KIND_START, issuer_pool[1], '0, 32'd100, 64'd101));
        send_item(make_item(KIND_ENTRY, '0, rand64(), '0, '0));
        send_item(make_item(KIND_QUERY, issuer_pool[1], cert, '0, '0));
        send_item(make_item(KIND_START, issuer_pool[2], '0, 32'd1, '1));
        send_item(make_item(KIND_START, issuer_pool[2], '0, '1, 64'h1_0000_0000));
    endtask

    task automatic test_table_full();
        for (int s = 3; s < SLOTS; s++)
            send_item(make_item(KIND_START, issuer_pool[s], '0, '0, '0));
        send_item(make_item(KIND_START, outsider_issuer, '0, '0, '0));
        send_item(make_item(KIND_ENTRY, '0, rand64(), '0, '0));
        send_item(make_item(KIND_START, issuer_pool[SLOTS - 1], '0, '0, '0));
    endtask

    task automatic test_list_full();
        logic [63:0] last_kept;
        logic [63:0] dropped;
        send_item(make_item(KIND_START, issuer_pool[SLOTS - 2], '0, '0, '0));
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            dropped = rand64();
            if (i == DEPTH - 1)
                last_kept = dropped;
            send_item(make_item(KIND_ENTRY, rand64(), dropped, $urandom, rand64()));
        end
        send_item(make_item(KIND_QUERY, issuer_pool[SLOTS - 2], last_kept, '0, '0));
        send_item(make_item(KIND_QUERY, issuer_pool[SLOTS - 2], dropped, '0, '0));
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
            if (i % 3 == 0)
                send_item(make_item(KIND_ENTRY, rand64(), rand64(), $urandom, rand64()));
            else
                send_known_query(issuer_pool[$urandom_range(SLOTS - 1)]);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          len;
        int          pick;
        logic [63:0] issuer;
        logic [63:0] now_v;
        logic [31:0] nu;
        rls_req_t    item;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                issuer = issuer_pool[$urandom_range(SLOTS - 1)];
                case ($urandom_range(3))
                    0:
                    begin
                        nu = '0;
                        now_v = rand64();
                    end
                    1:
                    begin
                        nu = $urandom | 32'd1;
                        now_v = {32'd0, 32'($urandom_range(nu))};
                    end
                    2:
                    begin
                        nu = $urandom | 32'd1;
                        now_v = rand64() | MOST_NEGATIVE;
                    end
                    default:
                    begin
                        nu = $urandom_range(32'hffff_fff0, 1);
                        now_v = {32'd0, nu} + 64'($urandom_range(1000, 1));
                    end
                endcase
                send_item(make_item(KIND_START, issuer, rand64(), nu, now_v));
                sent++;
                len = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 2, DEPTH - 2)
                                               : $urandom_range(10);
                repeat (len)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        send_known_query(issuer);
                        sent++;
                    end
                    send_item(make_item(KIND_ENTRY, rand64(), rand64(), $urandom, rand64()));
                    sent++;
                end
                repeat ($urandom_range(4))
                begin
                    send_known_query(issuer);
                    sent++;
                end
            end
            else if (pick < 85)
            begin
                send_known_query(issuer_pool[$urandom_range(SLOTS - 1)]);
                sent++;
            end
            else
            begin
                item = make_item(2'($urandom_range(3)), rand64(), rand64(), $urandom, rand64());
                send_item(item);
                if (item.kind != KIND_NONE)
                    sent++;
            end
        end
    endtask

    // receiver: phases of no stall, light stall and heavy stall, plus one long hold
    initial
    begin : receiver
        int mode_left;
        int stall_pct;
        rsp_stall = 1'b0;
        mode_left = 0;
        stall_pct = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(200, 10);
                    case ($urandom_range(2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 30;
                        default: stall_pct = 75;
                    endcase
                end
                mode_left--;
                rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        rls_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("unexpected result: status %0d revoked %0d", rsp.status, rsp.revoked);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.revoked !== want.revoked)
                begin
                    $error("revoked: expected %0d, actual %0d", want.revoked, rsp.revoked);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        burst_left = 0;
        error_count = 0;
        n_starts = 0; n_entries = 0; n_queries = 0; n_ignored = 0;
        n_stale = 0; n_table_full = 0; n_list_full = 0; n_no_load = 0; n_hits = 0;
        for (int s = 0; s < SLOTS; s++)
        begin
            shadow_keys[s]   = '0;
            shadow_used[s]   = 1'b0;
            shadow_counts[s] = 0;
            issuer_pool[s]   = rand64();
        end
        shadow_loading   = 1'b0;
        shadow_load_slot = 0;
        issuer_pool[0]   = '0;
        issuer_pool[1]   = '1;
        outsider_issuer  = issuer_pool[2] ^ 64'h1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_load_and_unknown_kind();
        test_load_and_query();
        test_stale_and_time_compare();
        test_table_full();
        test_list_full();
        test_backpressure();
        test_random_traffic();

        wait_for_results();
        repeat (40) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $error("%0d results never arrived", pending_outcomes.size());
            error_count++;
        end
        $display("covered %0d starts (%0d stale, %0d table full), %0d entries (%0d list full,",
                 n_starts, n_stale, n_table_full, n_entries, n_list_full);
        $display("  %0d without load), %0d lookups (%0d hits), %0d ignored items",
                 n_no_load, n_queries, n_hits, n_ignored);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rls_pkg.sv
rtl/rls_ctrl.sv
rtl/rls_datapath.sv
rtl/revocation_list_store_top.sv
sim/tb_revocation_list_store_top.sv
